FILE: design/sbrt_pkg.sv
// Package of the sub-block request tracker: payload structs, operation and
// status codes, divider handshake types and reset constants.
// No dependencies.
`default_nettype none

package sbrt_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_SUBS_DEF  = 256;
  localparam int PEER_BITS_DEF = 8;

  // Field and register widths.
  localparam int PIECE_W    = 23;
  localparam int SUB_W      = 17;
  localparam int OFFSET_W   = 22;
  localparam int LEN_W      = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 23;

  // Divider: the dividend covers piece_bytes + sub_bytes - 1.
  localparam int DIV_W = 24;
  localparam int DVS_W = 17;

  localparam logic [PIECE_W-1:0] PIECE_RST = 23'd262144;
  localparam logic [SUB_W-1:0]   SUB_RST   = 17'd16384;

  typedef enum logic [1:0] {
    OP_REQUEST = 2'd0,
    OP_RELEASE = 2'd1,
    OP_WRITE   = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_NONE   = 2'd1,
    STAT_REJECT = 2'd2
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PIECE = 2'd0,
    CFG_SUB   = 2'd1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CALC_GO,
    S_CALC,
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_WGO,
    S_WDIV,
    S_WCHK,
    S_RESP
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [7:0]          peer_id;
    logic [OFFSET_W-1:0] byte_offset;
    logic [LEN_W-1:0]    data_length;
  } in_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] sub_index;
    logic       piece_complete;
    logic [8:0] blocks_left;
    logic [8:0] blocks_unrequested;
  } out_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quot;
    logic [DVS_W-1:0] rem;
  } div_rsp_t;

endpackage

`default_nettype wire

FILE: design/sub_block_request_tracker.sv
// Top level of the sub-block request tracker: sequencer, counters and table.
// Depends on sbrt_pkg, sbrt_ram and sbrt_div.
//
// The block handles one beat at a time and is not ready while it works.
// Each table entry lives in one RAM word, read one per cycle with a
// registered read. A request scans from the first entry and stops at the
// first free sub-block; a release walks the whole table of n sub-blocks.
// A write goes through the shared 24-step divider; the write that completes
// the piece adds a clearing pass. After reset and after every configuration
// write the block divides to find n and then clears n entries before it
// accepts a beat. Configuration writes are always taken.
`default_nettype none

module sub_block_request_tracker import sbrt_pkg::*; #(
  parameter int MAX_SUBS  = MAX_SUBS_DEF,
  parameter int PEER_BITS = PEER_BITS_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_t                   in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_t                       out_data_o,
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IDX_W = $clog2(MAX_SUBS);
  localparam int CNT_W = $clog2(MAX_SUBS + 1);
  localparam int ENT_W = PEER_BITS + 2;
  localparam int RCV_B = PEER_BITS + 1;
  localparam int OWN_B = PEER_BITS;

  state_e               state_q, state_d;
  logic [PIECE_W-1:0]   piece_q, piece_d;
  logic [SUB_W-1:0]     sub_q, sub_d;
  logic [CNT_W-1:0]     n_q, n_d;
  logic [CNT_W-1:0]     left_q, left_d;
  logic [CNT_W-1:0]     free_q, free_d;
  logic                 done_q, done_d;
  logic [CNT_W-1:0]     rd_cnt_q, rd_cnt_d;
  logic                 chk_vld_q, chk_vld_d;
  logic [CNT_W-1:0]     clr_cnt_q, clr_cnt_d;
  logic                 reload_q, reload_d;

  op_e                  op_q, op_d;
  logic [PEER_BITS-1:0] peer_q, peer_d;
  logic [OFFSET_W-1:0]  offset_q, offset_d;
  logic [LEN_W-1:0]     len_q, len_d;
  logic [IDX_W-1:0]     chk_idx_q, chk_idx_d;
  logic                 wok_q, wok_d;
  logic [IDX_W-1:0]     widx_q, widx_d;
  status_e              status_q, status_d;
  logic [IDX_W-1:0]     idx_q, idx_d;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  logic [ENT_W-1:0]     ram_wdata;
  logic [IDX_W-1:0]     ram_raddr;
  logic [ENT_W-1:0]     ram_rdata;

  div_req_t             div_req;
  div_rsp_t             div_rsp;

  logic [SUB_W-1:0]     eff_sub;
  logic [PIECE_W-1:0]   rest;
  logic [LEN_W-1:0]     len_exp;
  logic [CNT_W-1:0]     left_dec;
  logic                 found;
  logic                 e_rcv;
  logic                 e_own;
  logic [PEER_BITS-1:0] e_peer;

  assign eff_sub = (sub_q == '0) ? SUB_W'(1) : sub_q;

  // Exact length of the sub-block that starts at the offset: a full
  // sub-block, or the tail of the piece when that is shorter.
  assign rest    = piece_q - {1'b0, offset_q};
  assign len_exp = (rest < PIECE_W'(eff_sub)) ? rest[LEN_W-1:0] : eff_sub;

  assign left_dec = (left_q != '0) ? left_q - 1'b1 : left_q;

  assign e_rcv  = ram_rdata[RCV_B];
  assign e_own  = ram_rdata[OWN_B];
  assign e_peer = ram_rdata[PEER_BITS-1:0];

  sbrt_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_SUBS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  sbrt_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    state_d   = state_q;
    piece_d   = piece_q;
    sub_d     = sub_q;
    n_d       = n_q;
    left_d    = left_q;
    free_d    = free_q;
    done_d    = done_q;
    rd_cnt_d  = rd_cnt_q;
    chk_vld_d = chk_vld_q;
    clr_cnt_d = clr_cnt_q;
    reload_d  = reload_q;
    op_d      = op_q;
    peer_d    = peer_q;
    offset_d  = offset_q;
    len_d     = len_q;
    chk_idx_d = chk_idx_q;
    wok_d     = wok_q;
    widx_d    = widx_q;
    status_d  = status_q;
    idx_d     = idx_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    found     = 1'b0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = DIV_W'(piece_q) + DIV_W'(eff_sub) - DIV_W'(1);
    div_req.divisor  = eff_sub;

    case (state_q)
      S_CALC_GO: begin
        div_req.start = 1'b1;
        state_d       = S_CALC;
      end

      S_CALC: begin
        if (div_rsp.done) begin
          n_d       = (div_rsp.quot > DIV_W'(MAX_SUBS)) ? CNT_W'(MAX_SUBS)
                                                        : CNT_W'(div_rsp.quot);
          clr_cnt_d = '0;
          reload_d  = 1'b1;
          state_d   = S_CLEAR;
        end
      end

      S_CLEAR: begin
        if (clr_cnt_q < n_q) begin
          ram_we    = 1'b1;
          ram_waddr = clr_cnt_q[IDX_W-1:0];
          clr_cnt_d = clr_cnt_q + 1'b1;
        end else if (reload_q) begin
          left_d  = n_q;
          free_d  = n_q;
          done_d  = 1'b0;
          state_d = S_IDLE;
        end else begin
          state_d = S_RESP;
        end
      end

      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          op_d      = in_data_i.op;
          peer_d    = PEER_BITS'(in_data_i.peer_id);
          offset_d  = in_data_i.byte_offset;
          len_d     = in_data_i.data_length;
          idx_d     = '0;
          status_d  = STAT_OK;
          rd_cnt_d  = '0;
          chk_vld_d = 1'b0;
          case (in_data_i.op)
            OP_REQUEST: begin
              if (done_q || free_q == '0) begin
                status_d = STAT_NONE;
                state_d  = S_RESP;
              end else begin
                state_d = S_SCAN;
              end
            end
            OP_RELEASE: state_d = S_SCAN;
            OP_WRITE:   state_d = S_WGO;
            default:    state_d = S_RESP;
          endcase
        end
      end

      S_SCAN: begin
        // Entry chk_idx_q is on the read data while the next read is issued.
        if (chk_vld_q) begin
          if (op_q == OP_REQUEST && !e_rcv && !e_own) begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_q;
            ram_wdata = {1'b0, 1'b1, peer_q};
            free_d    = free_q - 1'b1;
            status_d  = STAT_OK;
            idx_d     = chk_idx_q;
            chk_vld_d = 1'b0;
            found     = 1'b1;
            state_d   = S_RESP;
          end else if (op_q == OP_RELEASE && e_own && e_peer == peer_q && !e_rcv) begin
            ram_we    = 1'b1;
            ram_waddr = chk_idx_q;
            if (free_q < n_q) begin
              free_d = free_q + 1'b1;
            end
          end
        end
        if (!found) begin
          if (rd_cnt_q < n_q) begin
            ram_raddr = rd_cnt_q[IDX_W-1:0];
            rd_cnt_d  = rd_cnt_q + 1'b1;
            chk_vld_d = 1'b1;
            chk_idx_d = rd_cnt_q[IDX_W-1:0];
          end else begin
            chk_vld_d = 1'b0;
            if (!chk_vld_q) begin
              status_d = (op_q == OP_REQUEST) ? STAT_NONE : STAT_OK;
              idx_d    = '0;
              state_d  = S_RESP;
            end
          end
        end
      end

      S_WGO: begin
        div_req.start    = 1'b1;
        div_req.dividend = DIV_W'(offset_q);
        state_d          = S_WDIV;
      end

      S_WDIV: begin
        if (div_rsp.done) begin
          wok_d = !done_q && ({1'b0, offset_q} < piece_q) && (div_rsp.rem == '0) &&
                  (div_rsp.quot < DIV_W'(n_q)) && (len_q == len_exp);
          widx_d    = div_rsp.quot[IDX_W-1:0];
          ram_raddr = div_rsp.quot[IDX_W-1:0];
          state_d   = S_WCHK;
        end
      end

      S_WCHK: begin
        if (wok_q && !e_rcv) begin
          // The entry becomes received and loses its owner.
          ram_we    = 1'b1;
          ram_waddr = widx_q;
          ram_wdata = {1'b1, 1'b0, {PEER_BITS{1'b0}}};
          if (!e_own && free_q != '0) begin
            free_d = free_q - 1'b1;
          end
          left_d   = left_dec;
          status_d = STAT_OK;
          idx_d    = widx_q;
          if (left_dec == '0) begin
            // Last sub-block: the piece is complete and the table is cleared
            // before the result beat goes out.
            done_d    = 1'b1;
            clr_cnt_d = '0;
            reload_d  = 1'b0;
            state_d   = S_CLEAR;
          end else begin
            state_d = S_RESP;
          end
        end else begin
          status_d = STAT_REJECT;
          idx_d    = '0;
          state_d  = S_RESP;
        end
      end

      S_RESP: begin
        out_valid_o = 1'b1;
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_CALC_GO;
    endcase

    // A write to the piece or sub-block size register reloads everything from the new sizes.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PIECE: begin
          piece_d = cfg_data_i[PIECE_W-1:0];
          state_d = S_CALC_GO;
        end
        CFG_SUB: begin
          sub_d   = cfg_data_i[SUB_W-1:0];
          state_d = S_CALC_GO;
        end
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CALC_GO;
      piece_q   <= PIECE_RST;
      sub_q     <= SUB_RST;
      n_q       <= '0;
      left_q    <= '0;
      free_q    <= '0;
      done_q    <= 1'b0;
      rd_cnt_q  <= '0;
      chk_vld_q <= 1'b0;
      clr_cnt_q <= '0;
      reload_q  <= 1'b1;
    end else begin
      state_q   <= state_d;
      piece_q   <= piece_d;
      sub_q     <= sub_d;
      n_q       <= n_d;
      left_q    <= left_d;
      free_q    <= free_d;
      done_q    <= done_d;
      rd_cnt_q  <= rd_cnt_d;
      chk_vld_q <= chk_vld_d;
      clr_cnt_q <= clr_cnt_d;
      reload_q  <= reload_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    peer_q    <= peer_d;
    offset_q  <= offset_d;
    len_q     <= len_d;
    chk_idx_q <= chk_idx_d;
    wok_q     <= wok_d;
    widx_q    <= widx_d;
    status_q  <= status_d;
    idx_q     <= idx_d;
  end

  assign out_data_o.status             = status_q;
  assign out_data_o.sub_index          = 8'(idx_q);
  assign out_data_o.piece_complete     = done_q;
  assign out_data_o.blocks_left        = 9'(left_q);
  assign out_data_o.blocks_unrequested = 9'(free_q);

  // Only one beat is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o)
    else $error("input taken while a result is pending");

  // Between beats neither counter may exceed the sub-block count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (left_q <= n_q && free_q <= n_q))
    else $error("counter above sub-block count");

  // A completed piece has nothing left to receive.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (left_q == '0))
    else $error("piece complete with sub-blocks left");

  // The table is only walked or written after the count is known.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CALC && div_rsp.done) |=> (state_q == S_CLEAR || cfg_valid_i ||
                                             $past(cfg_valid_i)))
    else $error("count computed without a clearing pass");

endmodule

`default_nettype wire

FILE: design/sbrt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`default_nettype none

module sbrt_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

FILE: design/sbrt_div.sv
// Restoring divider shared by the sub-block count and the write offset check.
// One quotient bit per cycle. Depends on sbrt_pkg.
`default_nettype none

module sbrt_div import sbrt_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  localparam int DIV_CW = $clog2(DIV_W + 1);

  logic              busy_q;
  logic              done_q;
  logic [DIV_CW-1:0] cnt_q;
  logic [DIV_W-1:0]  dq_q;
  logic [DVS_W-1:0]  rem_q;
  logic [DVS_W-1:0]  dvs_q;

  logic [DVS_W:0] rem_sh;
  logic [DVS_W:0] diff;
  logic           ge;

  assign rem_sh = {rem_q, dq_q[DIV_W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign diff   = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= DIV_CW'(DIV_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == DIV_CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dq_q  <= req_i.dividend;
      rem_q <= '0;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DIV_W-2:0], ge};
      rem_q <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.quot = dq_q;
  assign rsp_o.rem  = rem_q;

endmodule

`default_nettype wire

FILE: tb/sv/sub_block_request_tracker_tb.sv
// Self-checking testbench for sub_block_request_tracker: directed and random
// beats, scored against an in-bench model of the tracker table and counters.
// Depends on sbrt_pkg and the sub_block_request_tracker RTL.
`default_nettype none

module sub_block_request_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sbrt_pkg::*;

  localparam int          TRACK_MAX     = MAX_SUBS_DEF;
  localparam int          CLK_HALF      = 4;
  localparam int          RESET_CYCLES  = 10;
  localparam int unsigned CYCLE_LIMIT   = 4_000_000;
  localparam int          SETTLE_CYCLES = 400;
  localparam int          RANDOM_ITEMS  = 1600;
  localparam int          REPORT_LIMIT  = 10;
  localparam int          LONG_HOLD     = 600;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  in_t                   in_data   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_t                  out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // Model of the tracker state.
  int unsigned piece_len;
  int unsigned sub_len_cfg;
  bit          got_block [TRACK_MAX];
  bit          owned     [TRACK_MAX];
  logic [7:0]  owner     [TRACK_MAX];
  int unsigned left_cnt;
  int unsigned free_cnt;
  bit          piece_done;

  out_t        expected_responses[$];
  int          error_count   = 0;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  int          hold_req      = 0;
  int          hold_left     = 0;
  int unsigned cycle_count   = 0;

  sub_block_request_tracker uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic longint unsigned eff_sub();
    return (sub_len_cfg == 0) ? 64'd1 : longint'(sub_len_cfg);
  endfunction

  function automatic int unsigned block_count();
    longint unsigned s;
    longint unsigned c;
    s = eff_sub();
    c = (longint'(piece_len) + s - 1) / s;
    return (c > TRACK_MAX) ? TRACK_MAX : int'(c);
  endfunction

  function automatic int unsigned block_len(int unsigned b);
    longint unsigned s;
    longint unsigned stop;
    longint unsigned start;
    s     = eff_sub();
    stop  = s * (longint'(b) + 1);
    start = s * longint'(b);
    if (stop > piece_len) stop = piece_len;
    return (stop > start) ? int'(stop - start) : 0;
  endfunction

  function automatic void clear_table();
    foreach (got_block[i]) begin
      got_block[i] = 1'b0;
      owned[i]     = 1'b0;
      owner[i]     = '0;
    end
  endfunction

  function automatic void reload_tracker();
    clear_table();
    left_cnt   = block_count();
    free_cnt   = left_cnt;
    piece_done = 1'b0;
  endfunction

  function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] value);
    if (idx == CFG_PIECE) begin
      piece_len = value[PIECE_W-1:0];
      reload_tracker();
    end else if (idx == CFG_SUB) begin
      sub_len_cfg = value[SUB_W-1:0];
      reload_tracker();
    end
  endfunction

  function automatic out_t track_beat(in_t beat);
    out_t            resp;
    int unsigned     n;
    longint unsigned s;
    longint unsigned b;
    longint unsigned off;
    bit              ok;
    n             = block_count();
    resp          = '0;
    resp.status   = STAT_OK;
    case (beat.op)
      OP_REQUEST: begin
        resp.status = STAT_NONE;
        if (!piece_done && free_cnt != 0) begin
          for (int unsigned i = 0; i < n; i++) begin
            if (!got_block[i] && !owned[i]) begin
              owned[i]       = 1'b1;
              owner[i]       = beat.peer_id;
              free_cnt--;
              resp.status    = STAT_OK;
              resp.sub_index = 8'(i);
              break;
            end
          end
        end
      end
      OP_RELEASE: begin
        for (int unsigned i = 0; i < n; i++) begin
          if (owned[i] && owner[i] == beat.peer_id && !got_block[i]) begin
            owned[i] = 1'b0;
            owner[i] = '0;
            if (free_cnt < n) free_cnt++;
          end
        end
      end
      OP_WRITE: begin
        s   = eff_sub();
        off = beat.byte_offset;
        b   = off / s;
        ok  = !piece_done && off < piece_len && (off % s) == 0 && b < n;
        if (ok) ok = beat.data_length == block_len(int'(b)) && !got_block[b];
        if (!ok) begin
          resp.status = STAT_REJECT;
        end else begin
          if (!owned[b] && free_cnt != 0) free_cnt--;
          got_block[b] = 1'b1;
          owned[b]     = 1'b0;
          owner[b]     = '0;
          if (left_cnt != 0) left_cnt--;
          resp.sub_index = 8'(b);
          if (left_cnt == 0) begin
            piece_done = 1'b1;
            clear_table();
          end
        end
      end
      default: ;
    endcase
    resp.piece_complete     = piece_done;
    resp.blocks_left        = left_cnt[8:0];
    resp.blocks_unrequested = free_cnt[8:0];
    return resp;
  endfunction

  function automatic in_t make_beat(op_e op, int unsigned peer, longint unsigned off,
                                    int unsigned len);
    in_t beat;
    beat.op          = op;
    beat.peer_id     = 8'(peer);
    beat.byte_offset = OFFSET_W'(off);
    beat.data_length = LEN_W'(len);
    return beat;
  endfunction

  function automatic void note_error(string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("ERROR at %0t: %s", $realtime, msg);
  endfunction

  // Result scoreboard: every accepted result beat is matched with the oldest prediction.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_responses.size() == 0) begin
        note_error($sformatf("unexpected result beat %p", out_data));
      end else begin
        want = expected_responses.pop_front();
        if (out_data.status !== want.status || out_data.sub_index !== want.sub_index ||
            out_data.piece_complete !== want.piece_complete ||
            out_data.blocks_left !== want.blocks_left ||
            out_data.blocks_unrequested !== want.blocks_unrequested)
          note_error($sformatf("expected %p, got %p", want, out_data));
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_beat(in_t beat);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!(in_valid && in_ready));
    expected_responses.push_back(track_beat(beat));
  endtask

  task automatic wait_results();
    in_valid <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(cfg_reg_e idx, logic [CFG_DATA_W-1:0] value);
    wait_results();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    apply_register(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic in_t random_beat();
    in_t             beat;
    int unsigned     n;
    int unsigned     pick;
    int unsigned     b;
    int unsigned     len;
    longint unsigned s;
    n                = block_count();
    s                = eff_sub();
    pick             = $urandom_range(99);
    beat.op          = OP_REQUEST;
    beat.peer_id     = ($urandom_range(3) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(5));
    beat.byte_offset = OFFSET_W'($urandom);
    beat.data_length = LEN_W'($urandom);
    if (pick < 38) begin
      beat.op = OP_REQUEST;
    end else if (pick < 48) begin
      beat.op = OP_RELEASE;
    end else begin
      beat.op = OP_WRITE;
      if (n != 0) begin
        b = $urandom_range(n - 1);
        // Mostly aim at a block still missing so that pieces do complete.
        if ($urandom_range(4) != 0) begin
          for (int unsigned j = 0; j < n; j++) begin
            if (!got_block[(b + j) % n]) begin
              b = (b + j) % n;
              break;
            end
          end
        end
        len              = block_len(b);
        beat.byte_offset = OFFSET_W'(s * b);
        beat.data_length = LEN_W'(len);
        if (pick >= 88) begin
          case ($urandom_range(3))
            0: beat.op = op_e'($urandom_range(3));
            1: beat.byte_offset = OFFSET_W'(s * b + 1);
            2: beat.data_length = ($urandom_range(1) != 0) ? LEN_W'(len + 1) : LEN_W'(len - 1);
            default: beat.op = OP_NONE;
          endcase
        end
      end
    end
    return beat;
  endfunction

  task automatic test_request_release();
    send_beat(make_beat(OP_REQUEST, 0, 0, 0));
    send_beat(make_beat(OP_REQUEST, 255, 4194303, 131071));
    send_beat(make_beat(OP_REQUEST, 0, 0, 0));
    send_beat(make_beat(OP_RELEASE, 0, 0, 0));
    send_beat(make_beat(OP_REQUEST, 7, 0, 0));
    send_beat(make_beat(OP_RELEASE, 255, 0, 0));
  endtask

  task automatic test_write_checks();
    // Owned block written, an unowned one, then a repeat and each malformed write.
    send_beat(make_beat(OP_WRITE, 0, 0, 16384));
    send_beat(make_beat(OP_WRITE, 0, 15 * 16384, 16384));
    send_beat(make_beat(OP_WRITE, 0, 15 * 16384, 16384));
    send_beat(make_beat(OP_WRITE, 0, 100, 16384));
    send_beat(make_beat(OP_WRITE, 0, 3 * 16384, 16383));
    send_beat(make_beat(OP_WRITE, 0, 262144, 16384));
    send_beat(make_beat(OP_WRITE, 255, 4194303, 131071));
    send_beat(make_beat(OP_NONE, 255, 4194303, 131071));
  endtask

  task automatic test_short_last_block();
    write_register(CFG_PIECE, 23'd1000);
    // Bits above the register width must be ignored.
    write_register(CFG_SUB, {6'h2a, 17'd300});
    send_beat(make_beat(OP_WRITE, 1, 0, 300));
    send_beat(make_beat(OP_REQUEST, 9, 0, 0));
    send_beat(make_beat(OP_WRITE, 9, 300, 300));
    send_beat(make_beat(OP_WRITE, 9, 900, 100));
    send_beat(make_beat(OP_WRITE, 9, 600, 300));
    send_beat(make_beat(OP_REQUEST, 9, 0, 0));
    send_beat(make_beat(OP_WRITE, 9, 0, 300));
  endtask

  task automatic test_zero_and_saturated();
    write_register(CFG_PIECE, 23'd0);
    send_beat(make_beat(OP_REQUEST, 1, 0, 0));
    write_register(CFG_SUB, 23'd0);
    write_register(CFG_PIECE, 23'd3);
    send_beat(make_beat(OP_WRITE, 1, 1, 1));
    write_register(CFG_SUB, 23'd1);
    write_register(CFG_PIECE, 23'd4194304);
    send_beat(make_beat(OP_WRITE, 1, 256, 1));
    send_beat(make_beat(OP_WRITE, 1, 255, 1));
    write_register(CFG_SUB, 23'd65536);
    send_beat(make_beat(OP_WRITE, 1, 4128768, 65536));
  endtask

  task automatic test_backpressure();
    // The first register write of the random test waits for these results.
    write_register(CFG_SUB, 23'd16384);
    write_register(CFG_PIECE, 23'd262144);
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = LONG_HOLD;
    for (int i = 0; i < 12; i++) send_beat(random_beat());
  endtask

  task automatic test_random();
    int          sent_random;
    int          seg;
    int          seg_len;
    int          after_done;
    int unsigned sub_pick;
    int unsigned piece_pick;
    longint unsigned span;
    sent_random = 0;
    seg         = 0;
    while (sent_random < RANDOM_ITEMS) begin
      case ($urandom_range(9))
        0: begin
          sub_pick   = $urandom_range(1, 64);
          piece_pick = $urandom_range(sub_pick * 200, 4194304);
        end
        1: begin
          sub_pick   = 0;
          piece_pick = $urandom_range(0, 40);
        end
        default: begin
          sub_pick = $urandom_range(1, 65536);
          span     = longint'(sub_pick) * $urandom_range(1, 24) - $urandom_range(0, sub_pick - 1);
          piece_pick = (span > 4194304) ? 4194304 : int'(span);
        end
      endcase
      if ($urandom_range(3) != 0) write_register(CFG_SUB, CFG_DATA_W'(sub_pick));
      write_register(CFG_PIECE, CFG_DATA_W'(piece_pick));
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      seg_len    = $urandom_range(30, 90);
      after_done = 0;
      for (int i = 0; i < seg_len && after_done < 4; i++) begin
        send_beat(random_beat());
        sent_random++;
        if (piece_done) after_done++;
      end
      seg++;
    end
  endtask

  initial begin
    piece_len   = PIECE_RST;
    sub_len_cfg = SUB_RST;
    reload_tracker();
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_request_release();
    test_write_checks();
    test_short_last_block();
    test_zero_and_saturated();
    test_backpressure();
    test_random();
    wait_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: sim.f
design/sbrt_pkg.sv
design/sbrt_ram.sv
design/sbrt_div.sv
design/sub_block_request_tracker.sv
tb/sv/sub_block_request_tracker_tb.sv
